/* src/saturating_fixed_point_alu_defines.svh */
// Assertion macros used by the top-level RTL file.
`ifndef SATURATING_FIXED_POINT_ALU_DEFINES_SVH
`define SATURATING_FIXED_POINT_ALU_DEFINES_SVH

`define SFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/sfa_pkg.sv */
`default_nettype none
package sfa_pkg;
    localparam int FRAC_BITS = 8;
    localparam int W = 32;
    localparam int QW = W + FRAC_BITS + 1;
    localparam int NCELL = QW;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_MIN = 3'd4,
        ACT_MAX = 3'd5
    } t_action;

    typedef struct packed {
        logic                 valid;
        logic [2:0]           action;
        logic [W-1:0]         fast;
        logic                 sat;
        logic                 dbz;
        logic                 a_less;
        logic                 eq;
        logic                 neg;
        logic [2*W-1:0]       prod;
        logic [QW:0]          rem;
        logic [QW-1:0]        num;
        logic [W-1:0]         den;
    } t_beat;

    function automatic logic [W:0] sat_fn(input logic signed [2*W+1:0] v);
        logic signed [2*W+1:0] mx;
        logic signed [2*W+1:0] mn;
        mx = {{(W+3){1'b0}}, {(W-1){1'b1}}};
        mn = {{(W+3){1'b1}}, {(W-1){1'b0}}};
        if (v > mx) begin
            return {1'b1, mx[W-1:0]};
        end else if (v < mn) begin
            return {1'b1, mn[W-1:0]};
        end
        return {1'b0, v[W-1:0]};
    endfunction
endpackage
`default_nettype wire

/* src/sfa_stream_if.sv */
`default_nettype none
interface sfa_stream_if #(
    parameter int WIDTH = 1
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/sfa_div_cell.sv */
`default_nettype none
// One restoring-division step on the magnitudes; the quotient bit shifts into num.
module sfa_div_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire sfa_pkg::t_beat  i_beat,
    output sfa_pkg::t_beat       o_beat
);
    sfa_pkg::t_beat n_beat;
    logic [sfa_pkg::QW:0] shifted;
    logic [sfa_pkg::QW:0] diff;

    always_comb begin
        n_beat = i_beat;
        shifted = {i_beat.rem[sfa_pkg::QW-1:0], i_beat.num[sfa_pkg::QW-1]};
        diff = shifted - {{(sfa_pkg::QW+1-sfa_pkg::W){1'b0}}, i_beat.den};
        if (!diff[sfa_pkg::QW]) begin
            n_beat.rem = diff;
            n_beat.num = {i_beat.num[sfa_pkg::QW-2:0], 1'b1};
        end else begin
            n_beat.rem = shifted;
            n_beat.num = {i_beat.num[sfa_pkg::QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_beat.valid <= 1'b0;
        end else if (i_en) begin
            o_beat <= n_beat;
        end
    end
endmodule
`default_nettype wire

/* src/saturating_fixed_point_alu.sv */
`default_nettype none
// Channel   Dir  Payload
// i_op      in   action, operand_a, operand_b
// o_res     out  result, saturated, divide_by_zero, a_less, operands_equal
// One beat is accepted per cycle while the pipeline is not stalled; a result passes one input
// stage, the chain of division cells and one output stage before it is valid.
// The chain of division cells sets the latency; every action walks the same chain.
// The whole pipeline stalls while a result waits at the output and the sink is not ready.
// Reset is synchronous and active low and clears only valid bits.
`include "saturating_fixed_point_alu_defines.svh"
module saturating_fixed_point_alu (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sfa_stream_if.sink   i_op,
    sfa_stream_if.source o_res
);
    localparam int W  = sfa_pkg::W;
    localparam int QW = sfa_pkg::QW;
    localparam int N  = sfa_pkg::NCELL;

    logic en;
    sfa_pkg::t_beat r_s0, n_s0, n_s1;
    sfa_pkg::t_beat chain [0:N];
    logic [W+3:0] r_out;
    logic r_out_v;

    logic [2:0] act;
    logic signed [W-1:0] a, b;
    logic [W:0] tmp;
    logic signed [QW:0] nsh;
    logic signed [QW:0] half;
    logic signed [QW:0] nadj;

    assign en = !r_out_v || o_res.ready;
    assign i_op.ready = en;
    assign act = i_op.data[2*W+2:2*W];
    assign a = i_op.data[2*W-1:W];
    assign b = i_op.data[W-1:0];

    // Stage 0: compare, add/sub, min/max, multiply, numerator and denominator setup.
    always_comb begin
        n_s0 = '0;
        n_s0.valid = i_op.valid;
        n_s0.action = act;
        n_s0.a_less = a < b;
        n_s0.eq = a == b;
        n_s0.prod = a * b;
        n_s0.den = b[W-1] ? W'(-b) : b;
        n_s0.dbz = (act == sfa_pkg::ACT_DIV) && (b == '0);
        nsh = (QW+1)'(a) <<< sfa_pkg::FRAC_BITS;
        half = (QW+1)'(b / 2);
        if ((nsh < 0 && b > 0) || (nsh > 0 && b < 0)) begin
            nadj = nsh - half;
        end else begin
            nadj = nsh + half;
        end
        n_s0.neg = nadj[QW] ^ b[W-1];
        n_s0.num = nadj[QW] ? QW'(-nadj) : QW'(nadj);
        tmp = '0;
        case (act)
            sfa_pkg::ACT_ADD: tmp = sfa_pkg::sat_fn(66'(a) + 66'(b));
            sfa_pkg::ACT_SUB: tmp = sfa_pkg::sat_fn(66'(a) - 66'(b));
            sfa_pkg::ACT_MIN: tmp = {1'b0, (a <= b) ? a : b};
            sfa_pkg::ACT_MAX: tmp = {1'b0, (a >= b) ? a : b};
            default: tmp = '0;
        endcase
        n_s0.sat = tmp[W];
        n_s0.fast = tmp[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (en) begin
            r_s0 <= n_s0;
        end
    end

    assign chain[0] = r_s0;
    for (genvar g = 0; g < N; g++) begin : g_cell
        sfa_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_beat(chain[g]), .o_beat(chain[g+1])
        );
    end

    // Final stage: sign fix, multiply shift, saturation, zero result on divide by zero.
    logic signed [2*W+1:0] q;
    logic [W:0] fin;
    always_comb begin
        n_s1 = chain[N];
        q = chain[N].neg ? -(2*W+2)'(chain[N].num) : (2*W+2)'(chain[N].num);
        case (chain[N].action)
            sfa_pkg::ACT_MUL: fin = sfa_pkg::sat_fn(
                (2*W+2)'($signed(chain[N].prod)) >>> sfa_pkg::FRAC_BITS);
            sfa_pkg::ACT_DIV: fin = chain[N].dbz ? '0 : sfa_pkg::sat_fn(q);
            default: fin = {chain[N].sat, chain[N].fast};
        endcase
        n_s1.sat = fin[W];
        n_s1.fast = fin[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= n_s1.valid;
            r_out <= {n_s1.fast, n_s1.sat, n_s1.dbz, n_s1.a_less, n_s1.eq};
        end
    end

    assign o_res.valid = r_out_v;
    assign o_res.data = r_out;

    `SFA_ASSERT_IMPL(a_dbz_zero, i_clk, i_rst_n, r_out_v && r_out[2], r_out[W+3:4] == '0)
    `SFA_ASSERT_IMPL(a_dbz_nosat, i_clk, i_rst_n, r_out_v && r_out[2], !r_out[3])
    `SFA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_out_v && !o_res.ready, r_out_v)
endmodule
`default_nettype wire

/* tb/saturating_fixed_point_alu_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module saturating_fixed_point_alu_tb;
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] WORD_MIN = 32'sh80000000;
    localparam int DRAIN_CYCLES = sfa_pkg::QW + 20;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_op_beat;

    typedef struct packed {
        logic signed [31:0] result;
        logic               saturated;
        logic               divide_by_zero;
        logic               a_less;
        logic               operands_equal;
    } t_res_beat;

    typedef struct {
        t_op_beat  op;
        bit        known;
        t_res_beat res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    sfa_stream_if #(.WIDTH($bits(t_op_beat)))  op_if ();
    sfa_stream_if #(.WIDTH($bits(t_res_beat))) res_if ();

    saturating_fixed_point_alu u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_op   (op_if.sink),
        .o_res  (res_if.source)
    );

    t_res_beat pending_results[$];
    t_row      directed_rows[$];
    int        error_count;
    int        res_wait;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] clamp_word(input longint v, ref logic sat);
        if (v > longint'(WORD_MAX)) begin
            sat = 1'b1;
            return WORD_MAX;
        end
        if (v < longint'(WORD_MIN)) begin
            sat = 1'b1;
            return WORD_MIN;
        end
        return v[31:0];
    endfunction

    function automatic t_res_beat compute_alu(input t_op_beat op);
        t_res_beat r;
        longint    a;
        longint    b;
        longint    n;
        longint    half;
        logic      sat;
        a = longint'(op.operand_a);
        b = longint'(op.operand_b);
        sat = 1'b0;
        r = '0;
        case (op.action)
            sfa_pkg::ACT_ADD: r.result = clamp_word(a + b, sat);
            sfa_pkg::ACT_SUB: r.result = clamp_word(a - b, sat);
            sfa_pkg::ACT_MUL: r.result = clamp_word((a * b) >>> sfa_pkg::FRAC_BITS, sat);
            sfa_pkg::ACT_DIV: begin
                if (b == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    n = a * (longint'(1) <<< sfa_pkg::FRAC_BITS);
                    half = b / 2;
                    if ((n < 0 && b > 0) || (n > 0 && b < 0)) begin
                        n = n - half;
                    end else begin
                        n = n + half;
                    end
                    r.result = clamp_word(n / b, sat);
                end
            end
            sfa_pkg::ACT_MIN: r.result = (a <= b) ? op.operand_a : op.operand_b;
            sfa_pkg::ACT_MAX: r.result = (a >= b) ? op.operand_a : op.operand_b;
            default: r.result = '0;
        endcase
        r.saturated = sat;
        r.a_less = a < b;
        r.operands_equal = a == b;
        return r;
    endfunction

    task automatic add_row(input logic [2:0] act, input logic signed [31:0] a,
                           input logic signed [31:0] b, input bit known,
                           input t_res_beat res);
        t_row row;
        row.op = '{action: act, operand_a: a, operand_b: b};
        row.known = known;
        row.res = res;
        directed_rows.push_back(row);
    endtask

    function automatic logic signed [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return WORD_MAX - $urandom_range(0, 3);
            1: return WORD_MIN + $urandom_range(0, 3);
            2: return $signed($urandom_range(0, 2047)) - 1024;
            3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input t_op_beat op, input t_res_beat expected);
        int gap;
        gap = $urandom_range(0, 11);
        if (gap > 0) begin
            op_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        op_if.valid <= 1'b1;
        op_if.data <= op;
        @(posedge i_clk);
        while (!op_if.ready) @(posedge i_clk);
        pending_results.push_back(expected);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_wait = $urandom_range(0, 11);
            res_if.ready <= 1'b0;
        end else if (res_if.valid && res_if.ready) begin
            res_wait = $urandom_range(0, 11);
            res_if.ready <= (res_wait == 0);
        end else if (res_wait > 0) begin
            res_wait--;
            res_if.ready <= (res_wait == 0);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_res_beat got;
        t_res_beat want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat %h", got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.result !== want.result) begin
                    $error("result: expected %h, got %h", want.result, got.result);
                    error_count++;
                end
                if (got.saturated !== want.saturated) begin
                    $error("saturated: expected %b, got %b", want.saturated, got.saturated);
                    error_count++;
                end
                if (got.divide_by_zero !== want.divide_by_zero) begin
                    $error("divide_by_zero: expected %b, got %b",
                           want.divide_by_zero, got.divide_by_zero);
                    error_count++;
                end
                if (got.a_less !== want.a_less) begin
                    $error("a_less: expected %b, got %b", want.a_less, got.a_less);
                    error_count++;
                end
                if (got.operands_equal !== want.operands_equal) begin
                    $error("operands_equal: expected %b, got %b",
                           want.operands_equal, got.operands_equal);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_op_beat op;
        int       wait_cycles;
        error_count = 0;
        i_rst_n = 1'b0;
        op_if.valid = 1'b0;
        op_if.data = '0;

        add_row(sfa_pkg::ACT_ADD, 0, 0, 1, '{32'sd0, 0, 0, 0, 1});
        add_row(sfa_pkg::ACT_ADD, WORD_MAX, WORD_MAX, 1, '{WORD_MAX, 1, 0, 0, 1});
        add_row(sfa_pkg::ACT_ADD, WORD_MIN, WORD_MIN, 1, '{WORD_MIN, 1, 0, 0, 1});
        add_row(sfa_pkg::ACT_SUB, WORD_MIN, 32'sd1, 1, '{WORD_MIN, 1, 0, 1, 0});
        add_row(sfa_pkg::ACT_SUB, WORD_MAX, -32'sd1, 1, '{WORD_MAX, 1, 0, 0, 0});
        add_row(sfa_pkg::ACT_SUB, 32'sd1000, -32'sd24, 0, '0);
        add_row(sfa_pkg::ACT_MUL, WORD_MAX, WORD_MAX, 1, '{WORD_MAX, 1, 0, 0, 1});
        add_row(sfa_pkg::ACT_MUL, WORD_MIN, WORD_MAX, 1, '{WORD_MIN, 1, 0, 1, 0});
        add_row(sfa_pkg::ACT_MUL, -32'sd384, 32'sd3, 0, '0);
        add_row(sfa_pkg::ACT_MUL, -32'sd1, 32'sd1, 0, '0);
        add_row(sfa_pkg::ACT_DIV, 32'sd256, 32'sd0, 1, '{32'sd0, 0, 1, 0, 0});
        add_row(sfa_pkg::ACT_DIV, WORD_MIN, 32'sd0, 1, '{32'sd0, 0, 1, 1, 0});
        add_row(sfa_pkg::ACT_DIV, WORD_MAX, 32'sd1, 1, '{WORD_MAX, 1, 0, 0, 0});
        add_row(sfa_pkg::ACT_DIV, WORD_MIN, -32'sd1, 1, '{WORD_MAX, 1, 0, 1, 0});
        add_row(sfa_pkg::ACT_DIV, 32'sd256, 32'sd3, 0, '0);
        add_row(sfa_pkg::ACT_DIV, -32'sd256, 32'sd3, 0, '0);
        add_row(sfa_pkg::ACT_DIV, 32'sd5, -32'sd7, 0, '0);
        add_row(sfa_pkg::ACT_DIV, 32'sd0, -32'sd7, 0, '0);
        add_row(sfa_pkg::ACT_MIN, WORD_MIN, WORD_MAX, 1, '{WORD_MIN, 0, 0, 1, 0});
        add_row(sfa_pkg::ACT_MIN, WORD_MAX, WORD_MAX, 1, '{WORD_MAX, 0, 0, 0, 1});
        add_row(sfa_pkg::ACT_MAX, WORD_MIN, WORD_MAX, 1, '{WORD_MAX, 0, 0, 1, 0});
        add_row(sfa_pkg::ACT_MAX, 32'sd7, -32'sd7, 1, '{32'sd7, 0, 0, 0, 0});
        add_row(ACT_SPARE6, 32'sd3, 32'sd4, 1, '{32'sd0, 0, 0, 1, 0});
        add_row(ACT_SPARE7, WORD_MAX, WORD_MAX, 1, '{32'sd0, 0, 0, 0, 1});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].op,
                      directed_rows[i].known ? directed_rows[i].res
                                             : compute_alu(directed_rows[i].op));
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            op.action = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                     : 3'($urandom_range(0, 5));
            op.operand_a = random_operand();
            case ($urandom_range(0, 9))
                0: op.operand_b = '0;
                1: op.operand_b = op.operand_a;
                default: op.operand_b = random_operand();
            endcase
            send_beat(op, compute_alu(op));
        end
        op_if.valid <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d result beats never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("saturating_fixed_point_alu_tb passed");
        end else begin
            $display("saturating_fixed_point_alu_tb failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("saturating_fixed_point_alu_tb failed");
        $finish;
    end
endmodule
`default_nettype wire

/* saturating_fixed_point_alu.f */
+incdir+src
src/sfa_pkg.sv
src/sfa_stream_if.sv
src/sfa_div_cell.sv
src/saturating_fixed_point_alu.sv
tb/saturating_fixed_point_alu_tb.sv
